>>> rtl/assert_macros.svh
// Assertion macros shared by the field/line offset converter RTL.
// Each macro expects signals named clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/flots_pkg.sv
// Package for the field/line offset to sub-sample converter.
// Holds status codes, video timing constants and the decode flag struct.
package flots_pkg;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_ZERO  = 3'd1;
  localparam logic [2:0] ST_MIXED = 3'd2;
  localparam logic [2:0] ST_OFS   = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  localparam logic [19:0] PAL_LINE_MAX_OFS  = 20'd442367;
  localparam logic [18:0] PAL_LINE_LEN      = 19'd442368;
  localparam logic [27:0] PAL_FIELD_PAIR    = 28'd138240000;
  localparam logic [19:0] NTSC_LINE_MAX_OFS = 20'd439295;
  localparam logic [18:0] NTSC_LINE_LEN     = 19'd439296;
  localparam logic [27:0] NTSC_FIELD_PAIR   = 28'd115315200;

  localparam logic signed [11:0] PAL_ODD_LINE      = 12'sd313;
  localparam logic signed [11:0] PAL_NEG_ODD_LINE  = 12'sd624;
  localparam logic signed [11:0] PAL_NEG_EVEN_LINE = 12'sd312;
  localparam logic signed [11:0] NTSC_ODD_LINE     = 12'sd263;
  localparam logic signed [11:0] NTSC_NEG_ODD_LINE = 12'sd524;
  localparam logic signed [11:0] NTSC_NEG_EVEN_LINE = 12'sd262;
  localparam logic signed [4:0]  PAL_NEG_FIELD_STEP  = 5'sd7;
  localparam logic signed [4:0]  NTSC_NEG_FIELD_STEP = 5'sd3;

  // Offset scaling: samples = (432 * |t| + bias) / 625, with bias 312 for a
  // non-negative offset and -313 for a negative one.
  localparam logic [8:0]  OFS_SCALE    = 9'd432;
  localparam logic [8:0]  OFS_BIAS_POS = 9'd312;
  localparam logic [8:0]  OFS_BIAS_NEG = 9'd313;
  localparam logic [9:0]  OFS_DIVISOR  = 10'd625;
  localparam logic [22:0] RECIP_625    = 23'd6871947;

  typedef struct packed {
    logic       ntsc;
    logic       zero;
    logic       mixed;
    logic       range_bad;
    logic       minus;
    logic       t_zero;
    logic       t_neg;
    logic [2:0] fld_a;
    logic [9:0] ln_a;
  } flots_flags_t;

endpackage

>>> rtl/flots_ifs.sv
// Valid/ready channel interfaces for the field/line offset converter.
// Depends on nothing; payload widths are fixed by the item format.
interface flots_item_if;
  logic               valid;
  logic               ready;
  logic               video_system;
  logic signed [3:0]  field_number;
  logic signed [10:0] line_number;
  logic signed [20:0] offset_tenths_ns;

  modport source (output valid, video_system, field_number, line_number,
                  offset_tenths_ns, input ready);
  modport sink (input valid, video_system, field_number, line_number,
                offset_tenths_ns, output ready);
endinterface

interface flots_result_if;
  logic        valid;
  logic        ready;
  logic [30:0] sample_delay;
  logic [2:0]  status;

  modport source (output valid, sample_delay, status, input ready);
  modport sink (input valid, sample_delay, status, output ready);
endinterface

>>> rtl/field_line_offset_to_samples_unit.sv
// Field/line/offset to 1/256 sub-sample converter, top level.
// Depends on flots_pkg, flots_ifs, flots_decode, flots_ofs_conv and
// assert_macros.svh.
//
// Usage:
//   item carries one delay word (video system, field, line, offset in
//   0.1 ns units); result returns one word per item with sample_delay and
//   status. Both channels use valid/ready and move a word on a clock edge
//   where both are high.
//   Throughput is one word per cycle while result.ready is high, set by
//   a four-register pipeline: input register, reciprocal multiply
//   register, correction and field/line product register, and the
//   output register.
//   When the receiver stalls, words stay in the pipeline; bubbles are
//   squeezed out, and item.ready falls only when all four stages hold a
//   word. Reset clears every valid bit; no word is lost or repeated.
//   A word with a nonzero status reports sample_delay as zero.
`include "assert_macros.svh"

module field_line_offset_to_samples_unit import flots_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  flots_item_if.sink     item,
  flots_result_if.source result
);

  logic               v1, v2, v3, v_out;
  logic               rdy1, rdy2, rdy3, rdy_out;
  logic               sys_r;
  logic signed [3:0]  fld_r;
  logic signed [10:0] ln_r;
  logic signed [20:0] t_r;
  flots_flags_t       flags_dec, flags2, flags3;
  logic [19:0]        q;
  logic [30:0]        base;
  logic [30:0]        base_next;
  logic [19:0]        max_ofs;
  logic signed [21:0] smp;
  logic signed [32:0] res;
  logic [2:0]         status_next;
  logic [30:0]        sample_delay;
  logic [2:0]         status;

  assign rdy_out = !v_out || result.ready;
  assign rdy3    = !v3 || rdy_out;
  assign rdy2    = !v2 || rdy3;
  assign rdy1    = !v1 || rdy2;
  assign item.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v_out <= 1'b0;
    end else begin
      if (rdy1)    v1    <= item.valid;
      if (rdy2)    v2    <= v1;
      if (rdy3)    v3    <= v2;
      if (rdy_out) v_out <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && item.valid) begin
      sys_r <= item.video_system;
      fld_r <= item.field_number;
      ln_r  <= item.line_number;
      t_r   <= item.offset_tenths_ns;
    end
  end

  flots_decode u_decode (
    .ntsc  (sys_r),
    .fld   (fld_r),
    .ln    (ln_r),
    .t     (t_r),
    .flags (flags_dec)
  );

  flots_ofs_conv u_ofs_conv (
    .clk  (clk),
    .rst  (rst),
    .en_a (rdy2 && v1),
    .en_b (rdy3 && v2),
    .t    (t_r),
    .q    (q)
  );

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      flags2 <= flags_dec;
    end
  end

  assign base_next = flags2.ntsc
      ? 31'(31'(flags2.fld_a) * 31'(NTSC_FIELD_PAIR)
            + 31'(flags2.ln_a) * 31'(NTSC_LINE_LEN))
      : 31'(31'(flags2.fld_a) * 31'(PAL_FIELD_PAIR)
            + 31'(flags2.ln_a) * 31'(PAL_LINE_LEN));

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      flags3 <= flags2;
      base   <= base_next;
    end
  end

  assign max_ofs = flags3.ntsc ? NTSC_LINE_MAX_OFS : PAL_LINE_MAX_OFS;

  always_comb begin
    smp = flags3.t_neg ? -$signed(22'(q)) : $signed(22'(q));
    if (flags3.minus) begin
      smp = smp + $signed(22'(max_ofs)) + $signed(22'(flags3.t_zero));
    end
    res = $signed({2'b00, base}) + 33'(smp);
    if (flags3.zero) begin
      status_next = ST_ZERO;
    end else if (flags3.mixed) begin
      status_next = ST_MIXED;
    end else if (q > max_ofs) begin
      status_next = ST_OFS;
    end else if (flags3.range_bad) begin
      status_next = ST_RANGE;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && v3) begin
      status       <= status_next;
      sample_delay <= ((status_next != ST_OK) || res[32]) ? 31'd0 : res[30:0];
    end
  end

  assign result.valid        = v_out;
  assign result.sample_delay = sample_delay;
  assign result.status       = status;

  `CHK_IMPLY(a_err_zero_delay, result.valid && (result.status != ST_OK),
             result.sample_delay == 31'd0, "error word with nonzero delay")
  `CHK_IMPLY(a_status_code, result.valid, result.status <= ST_RANGE,
             "status code out of range")
  `CHK_IMPLY(a_stall_full, !item.ready, v1 && v2 && v3 && result.valid,
             "input stalled while pipeline has room")
  `CHK_NEXT(a_drain, v3 && result.ready, result.valid,
            "last stage failed to reach output register")

endmodule

>>> rtl/flots_decode.sv
// Sign, range-table and field/line normalization decode for one word.
// Depends on flots_pkg for constants and the flag struct.
module flots_decode import flots_pkg::*; (
  input  logic               ntsc,
  input  logic signed [3:0]  fld,
  input  logic signed [10:0] ln,
  input  logic signed [20:0] t,
  output flots_flags_t       flags
);

  logic              all_le;
  logic              all_ge;
  logic              minus;
  logic              ok;
  logic signed [4:0] f5;
  logic signed [4:0] fs;
  logic signed [4:0] fa;
  logic signed [11:0] l12;
  logic signed [11:0] la;

  assign all_le = (fld <= 4'sd0) && (ln <= 11'sd0) && (t <= 21'sd0);
  assign all_ge = (fld >= 4'sd0) && (ln >= 11'sd0) && (t >= 21'sd0);
  assign minus  = all_le;
  assign f5     = 5'(fld);
  assign l12    = 12'(ln);

  always_comb begin
    ok = 1'b0;
    if (!ntsc) begin
      case (fld)
        4'sd0: ok = minus ? (ln >= -11'sd311) : (ln <= 11'sd312);
        -4'sd1, -4'sd3, 4'sd2: ok = (ln >= -11'sd312) && (ln <= 11'sd312);
        -4'sd2, 4'sd1, 4'sd3: ok = (ln >= -11'sd311) && (ln <= 11'sd311);
        4'sd4: ok = (ln <= 11'sd0) && (t <= 21'sd0);
        default: ok = 1'b0;
      endcase
    end else begin
      case (fld)
        4'sd0: ok = minus ? (ln >= -11'sd261) : (ln <= 11'sd262);
        -4'sd1: ok = (ln >= -11'sd262) && (ln <= 11'sd262);
        4'sd1: ok = (ln >= -11'sd261) && (ln <= 11'sd261);
        4'sd2: ok = (ln <= 11'sd0) && (t <= 21'sd0);
        default: ok = 1'b0;
      endcase
    end
  end

  always_comb begin
    fs = f5 + (ntsc ? NTSC_NEG_FIELD_STEP : PAL_NEG_FIELD_STEP);
    fa = f5;
    la = l12;
    if (!minus) begin
      if (fld[0]) begin
        la = l12 + (ntsc ? NTSC_ODD_LINE : PAL_ODD_LINE);
        fa = f5 - 5'sd1;
      end
    end else begin
      if (fs[0]) begin
        la = l12 + (ntsc ? NTSC_NEG_ODD_LINE : PAL_NEG_ODD_LINE);
        fa = fs - 5'sd1;
      end else begin
        la = l12 + (ntsc ? NTSC_NEG_EVEN_LINE : PAL_NEG_EVEN_LINE);
        fa = fs;
      end
    end
  end

  always_comb begin
    flags.ntsc      = ntsc;
    flags.zero      = (fld == 4'sd0) && (ln == 11'sd0) && (t == 21'sd0);
    flags.mixed     = !all_le && !all_ge;
    flags.range_bad = !ok;
    flags.minus     = minus;
    flags.t_zero    = (t == 21'sd0);
    flags.t_neg     = t[20];
    flags.fld_a     = fa[2:0];
    flags.ln_a      = la[9:0];
  end

endmodule

>>> rtl/flots_ofs_conv.sv
// Two-stage offset scaler: |t| * 432 / 625 with round-half-up bias,
// done by a reciprocal multiply and one remainder correction.
// Depends on flots_pkg and assert_macros.svh.
`include "assert_macros.svh"

module flots_ofs_conv import flots_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en_a,
  input  logic               en_b,
  input  logic signed [20:0] t,
  output logic [19:0]        q
);

  logic [20:0] mag;
  logic [28:0] x;
  logic [51:0] prod;
  logic [19:0] q_est;
  logic [28:0] x_r;
  logic [28:0] rem;

  assign mag  = t[20] ? 21'(-t) : 21'(t);
  assign x    = t[20] ? (29'(mag) * 29'(OFS_SCALE) - 29'(OFS_BIAS_NEG))
                      : (29'(mag) * 29'(OFS_SCALE) + 29'(OFS_BIAS_POS));
  assign prod = 52'(x) * 52'(RECIP_625);

  always_ff @(posedge clk) begin
    if (en_a) begin
      q_est <= prod[51:32];
      x_r   <= x;
    end
  end

  assign rem = x_r - 29'(q_est) * 29'(OFS_DIVISOR);

  always_ff @(posedge clk) begin
    if (en_b) begin
      q <= (rem >= 29'(OFS_DIVISOR)) ? q_est + 20'd1 : q_est;
    end
  end

  `CHK_IMPLY(a_recip_one_step, en_b, rem < 29'(2 * OFS_DIVISOR),
             "reciprocal estimate off by more than one")

endmodule
